// ===== sv/beamformer_power_scan_defines.svh =====
// Assertion macros for the beamformer power scan RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef BEAMFORMER_POWER_SCAN_DEFINES_SVH
`define BEAMFORMER_POWER_SCAN_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bps_pkg.sv =====
// Types and constants for the beamformer power scan.
// No dependencies; imported by every module and interface of the block.
`timescale 1ns / 1ps

package bps_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PROD_W      = 32;
   localparam int TERM_W      = 33;
   localparam int SUM_W       = 40;
   localparam int BEAM_SHIFT  = 15;
   localparam int BEAM_W      = 24;
   localparam int SQ_W        = 47;
   localparam int MAG_W       = 48;
   localparam int POWER_W     = 58;
   localparam int DIR_W       = 14;
   localparam int QUEUE_DEPTH = 4;

   // One finished snapshot handed from the front to the back.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum_re;
      logic signed [SUM_W-1:0] sum_im;
      logic                    last_snapshot;
      logic [DIR_W-1:0]        direction;
      logic                    start_scan;
   } snap_type;

endpackage

// ===== sv/bps_req_if.sv =====
// Input channel: one array element word per handshake.
// Depends on bps_pkg for field widths.
`timescale 1ns / 1ps

interface bps_req_if;
   import bps_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;
   logic signed [SAMPLE_W-1:0] weight_re;
   logic signed [SAMPLE_W-1:0] weight_im;
   logic                       last_element;
   logic                       last_snapshot;
   logic [DIR_W-1:0]           direction_id;
   logic                       start_scan;

   modport source (
      output valid, sample_re, sample_im, weight_re, weight_im,
             last_element, last_snapshot, direction_id, start_scan,
      input  ready
   );
   modport sink (
      input  valid, sample_re, sample_im, weight_re, weight_im,
             last_element, last_snapshot, direction_id, start_scan,
      output ready
   );
endinterface

// ===== sv/bps_rsp_if.sv =====
// Result channel: one beam/power word per closed snapshot.
// Depends on bps_pkg for field widths.
`timescale 1ns / 1ps

interface bps_rsp_if;
   import bps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [BEAM_W-1:0] beam_re;
   logic signed [BEAM_W-1:0] beam_im;
   logic                     power_valid;
   logic [POWER_W-1:0]       power;
   logic                     new_peak;
   logic [DIR_W-1:0]         best_direction;
   logic [POWER_W-1:0]       peak_power;

   modport source (
      output valid, beam_re, beam_im, power_valid, power, new_peak,
             best_direction, peak_power,
      input  ready
   );
   modport sink (
      input  valid, beam_re, beam_im, power_valid, power, new_peak,
             best_direction, peak_power,
      output ready
   );
endinterface

// ===== sv/bps_front.sv =====
// Front end: accepts element words, multiplies, accumulates the complex sum
// and pushes one snapshot record per closing element. Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_front (
   input  logic               clock,
   input  logic               reset,
   bps_req_if.sink            req,
   output logic               push,
   output bps_pkg::snap_type  push_data,
   input  logic               full
);
   import bps_pkg::*;

   logic                      advance;
   logic                      s1_valid_ff;
   logic signed [PROD_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                      s1_last_el_ff, s1_last_snap_ff, s1_start_ff;
   logic [DIR_W-1:0]          s1_dir_ff;
   logic signed [SUM_W-1:0]   sum_re_ff, sum_im_ff;
   logic signed [SUM_W-1:0]   sum_re_in, sum_im_in;
   logic signed [TERM_W-1:0]  term_re, term_im;
   logic                      pend_start_ff, pend_start_in;
   logic                      eff_start;

   // Stall only when a closing element meets a full queue.
   assign advance   = !(s1_valid_ff && s1_last_el_ff && full);
   assign req.ready = advance;

   // Product stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
      if (advance) begin
         p_rr_ff         <= PROD_W'(req.weight_re) * PROD_W'(req.sample_re);
         p_ii_ff         <= PROD_W'(req.weight_im) * PROD_W'(req.sample_im);
         p_ri_ff         <= PROD_W'(req.weight_re) * PROD_W'(req.sample_im);
         p_ir_ff         <= PROD_W'(req.weight_im) * PROD_W'(req.sample_re);
         s1_last_el_ff   <= req.last_element;
         s1_last_snap_ff <= req.last_snapshot;
         s1_dir_ff       <= req.direction_id;
         s1_start_ff     <= req.start_scan;
      end
   end

   // Accumulate stage: conj(w) * s, wrapping in the sum width.
   always_comb begin
      term_re       = TERM_W'(p_rr_ff) + TERM_W'(p_ii_ff);
      term_im       = TERM_W'(p_ri_ff) - TERM_W'(p_ir_ff);
      sum_re_in     = sum_re_ff + SUM_W'(term_re);
      sum_im_in     = sum_im_ff + SUM_W'(term_im);
      eff_start     = pend_start_ff | s1_start_ff;
      pend_start_in = s1_last_el_ff ? 1'b0 : eff_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_re_ff     <= '0;
         sum_im_ff     <= '0;
         pend_start_ff <= 1'b0;
      end else if (advance && s1_valid_ff) begin
         sum_re_ff     <= s1_last_el_ff ? '0 : sum_re_in;
         sum_im_ff     <= s1_last_el_ff ? '0 : sum_im_in;
         pend_start_ff <= pend_start_in;
      end
   end

   assign push                    = s1_valid_ff && s1_last_el_ff && !full;
   assign push_data.sum_re        = sum_re_in;
   assign push_data.sum_im        = sum_im_in;
   assign push_data.last_snapshot = s1_last_snap_ff;
   assign push_data.direction     = s1_dir_ff;
   assign push_data.start_scan    = eff_start;

endmodule

// ===== sv/bps_queue.sv =====
// Short snapshot queue between front and back, in flip-flops.
// Depends on bps_pkg for the record type.
`timescale 1ns / 1ps

module bps_queue #(
   parameter int DEPTH = bps_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bps_pkg::snap_type  push_data,
   output logic               full,
   input  logic               pop,
   output bps_pkg::snap_type  head,
   output logic               empty
);
   import bps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   snap_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/bps_back.sv =====
// Back end: beam scaling, squared magnitude, saturating power and peak
// tracking, ending in the result register. Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_back (
   input  logic               clock,
   input  logic               reset,
   input  bps_pkg::snap_type  head,
   input  logic               empty,
   output logic               pop,
   bps_rsp_if.source          rsp
);
   import bps_pkg::*;

   localparam int SHIFT_W = SUM_W - BEAM_SHIFT;

   function automatic logic signed [BEAM_W-1:0] sat_beam(
      input logic signed [SHIFT_W-1:0] v
   );
      logic signed [BEAM_W-1:0] r;
      if (v > SHIFT_W'(signed'({1'b0, {(BEAM_W-1){1'b1}}}))) begin
         r = {1'b0, {(BEAM_W-1){1'b1}}};
      end else if (v < SHIFT_W'(signed'({1'b1, {(BEAM_W-1){1'b0}}}))) begin
         r = {1'b1, {(BEAM_W-1){1'b0}}};
      end else begin
         r = v[BEAM_W-1:0];
      end
      return r;
   endfunction

   logic                      advance;
   logic                      rsp_valid_ff;
   // beam stage
   logic                      b1_valid_ff;
   logic signed [BEAM_W-1:0]  b1_re_ff, b1_im_ff;
   logic                      b1_last_ff, b1_start_ff;
   logic [DIR_W-1:0]          b1_dir_ff;
   // square stage
   logic                      b2_valid_ff;
   logic signed [BEAM_W-1:0]  b2_re_ff, b2_im_ff;
   logic [SQ_W-1:0]           sq_re_ff, sq_im_ff;
   logic                      b2_last_ff, b2_start_ff;
   logic [DIR_W-1:0]          b2_dir_ff;
   logic signed [2*BEAM_W-1:0] sq_re_full, sq_im_full;
   // power and peak
   logic [POWER_W-1:0]        power_acc_ff, peak_value_ff;
   logic [DIR_W-1:0]          peak_dir_ff;
   logic [MAG_W-1:0]          mag;
   logic [POWER_W:0]          acc_sum;
   logic [POWER_W-1:0]        acc_new, peak_base, peak_in, power_acc_in;
   logic [DIR_W-1:0]          dir_base, dir_in;
   logic                      np;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign pop       = advance && !empty;
   assign rsp.valid = rsp_valid_ff;

   assign sq_re_full = (2*BEAM_W)'(b1_re_ff) * (2*BEAM_W)'(b1_re_ff);
   assign sq_im_full = (2*BEAM_W)'(b1_im_ff) * (2*BEAM_W)'(b1_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= !empty;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
      if (advance) begin
         b1_re_ff    <= sat_beam(head.sum_re[SUM_W-1:BEAM_SHIFT]);
         b1_im_ff    <= sat_beam(head.sum_im[SUM_W-1:BEAM_SHIFT]);
         b1_last_ff  <= head.last_snapshot;
         b1_start_ff <= head.start_scan;
         b1_dir_ff   <= head.direction;
         b2_re_ff    <= b1_re_ff;
         b2_im_ff    <= b1_im_ff;
         sq_re_ff    <= sq_re_full[SQ_W-1:0];
         sq_im_ff    <= sq_im_full[SQ_W-1:0];
         b2_last_ff  <= b1_last_ff;
         b2_start_ff <= b1_start_ff;
         b2_dir_ff   <= b1_dir_ff;
      end
   end

   always_comb begin
      mag          = MAG_W'(sq_re_ff) + MAG_W'(sq_im_ff);
      acc_sum      = (POWER_W+1)'(power_acc_ff) + (POWER_W+1)'(mag);
      acc_new      = acc_sum[POWER_W] ? '1 : acc_sum[POWER_W-1:0];
      peak_base    = b2_start_ff ? '0 : peak_value_ff;
      dir_base     = b2_start_ff ? '0 : peak_dir_ff;
      np           = b2_last_ff && (acc_new > peak_base);
      peak_in      = np ? acc_new : peak_base;
      dir_in       = np ? b2_dir_ff : dir_base;
      power_acc_in = b2_last_ff ? '0 : acc_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_acc_ff  <= '0;
         peak_value_ff <= '0;
         peak_dir_ff   <= '0;
      end else if (advance && b2_valid_ff) begin
         power_acc_ff  <= power_acc_in;
         peak_value_ff <= peak_in;
         peak_dir_ff   <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp.beam_re        <= b2_re_ff;
         rsp.beam_im        <= b2_im_ff;
         rsp.power_valid    <= b2_last_ff;
         rsp.power          <= b2_last_ff ? acc_new : '0;
         rsp.new_peak       <= np;
         rsp.best_direction <= dir_in;
         rsp.peak_power     <= peak_in;
      end
   end

endmodule

// ===== sv/beamformer_power_scan.sv =====
// Path of a closing element word: product, accumulate/queue write, beam, square,
//   then the result register. Throughput: one element word per cycle unless a
//   closing word meets a full queue; the result path, one per cycle while ready.
// Reset (synchronous): clears sums, pending scan start, power, peak and the queue.
`timescale 1ns / 1ps

`include "beamformer_power_scan_defines.svh"

module beamformer_power_scan #(
   parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   bps_req_if.sink   req,
   bps_rsp_if.source rsp
);
   import bps_pkg::*;

   // Snapshot records between front and back.
   logic     fifo_push, fifo_full, fifo_pop, fifo_empty;
   snap_type fifo_in, fifo_head;

   // Front: multiply each element by the conjugate weight and accumulate;
   // push one record when the last element of a snapshot arrives.
   bps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push      (fifo_push),
      .push_data (fifo_in),
      .full      (fifo_full)
   );

   // Queue: decouple the front from result backpressure.
   bps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .head      (fifo_head),
      .empty     (fifo_empty)
   );

   // Back: scale and saturate the beam, square it, fold it into the power
   // accumulator, track the peak, and hold the result word.
   bps_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (fifo_head),
      .empty (fifo_empty),
      .pop   (fifo_pop),
      .rsp   (rsp)
   );

   // Never write into a full queue.
   `BPS_ASSERT_IMPLIES(a_no_overflow, clock, reset, fifo_push, !fifo_full, "queue overflow")
   // Never read an empty queue.
   `BPS_ASSERT_IMPLIES(a_no_underflow, clock, reset, fifo_pop, !fifo_empty, "queue underflow")
   // A new peak carries its own power.
   `BPS_ASSERT_IMPLIES(a_peak_match, clock, reset, rsp.valid && rsp.new_peak,
      rsp.power_valid && rsp.peak_power == rsp.power && rsp.power != '0, "peak mismatch")
   // Without a closing direction the power field is zero.
   `BPS_ASSERT_IMPLIES(a_idle_power, clock, reset, rsp.valid && !rsp.power_valid,
      rsp.power == '0 && !rsp.new_peak, "power without close")

endmodule

// ===== sim/beamformer_power_scan_test.sv =====
// Self-checking bench for beamformer_power_scan: element words in, beam/power words out.
// Depends on bps_pkg, bps_req_if, bps_rsp_if and the beamformer_power_scan RTL.
`timescale 1ns / 1ps

module beamformer_power_scan_test;
   import bps_pkg::*;

   // Worst legal quiet stretch is a receiver stall plus the trip through the
   // result path; allow far more before calling it a hang.
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_WORDS   = 200;
   localparam int DRAIN_CYCLES   = 8;

   localparam logic [POWER_W-1:0] POWER_CAP = '1;
   localparam longint BEAM_TOP    = (longint'(1) << (BEAM_W - 1)) - 1;
   localparam longint BEAM_BOTTOM = -(longint'(1) << (BEAM_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic signed [SAMPLE_W-1:0] weight_re;
      logic signed [SAMPLE_W-1:0] weight_im;
      logic                       last_element;
      logic                       last_snapshot;
      logic [DIR_W-1:0]           direction_id;
      logic                       start_scan;
   } element_word_type;

   typedef struct packed {
      logic signed [BEAM_W-1:0] beam_re;
      logic signed [BEAM_W-1:0] beam_im;
      logic                     power_valid;
      logic [POWER_W-1:0]       power;
      logic                     new_peak;
      logic [DIR_W-1:0]         best_direction;
      logic [POWER_W-1:0]       peak_power;
   } beam_result_type;

   // One row of the directed table: the element word and, where the answer
   // is obvious by hand, the beam word it must produce.
   typedef struct packed {
      element_word_type word;
      logic             has_golden;
      beam_result_type  golden;
   } directed_row_type;

   localparam beam_result_type NO_GOLDEN = '0;

   logic clock = 1'b0;
   logic reset;

   bps_req_if req_bus ();
   bps_rsp_if rsp_bus ();

   beamformer_power_scan i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #1 clock = ~clock;

   // Predictor state: complex sum, power accumulator and the running peak.
   logic signed [SUM_W-1:0] sum_re_q  = '0;
   logic signed [SUM_W-1:0] sum_im_q  = '0;
   logic [POWER_W-1:0]      scan_power_q = '0;
   logic [POWER_W-1:0]      peak_power_q = '0;
   logic [DIR_W-1:0]        peak_dir_q   = '0;

   beam_result_type  beam_queue [$];
   directed_row_type directed_rows [$];

   int  mismatches   = 0;
   int  quiet_cycles = 0;
   int  burst_left   = 1;
   bit  gaps_on      = 1'b1;
   int  random_words = 0;

   function automatic element_word_type elem_word(input int sr, si, wr, wi, input bit le, ls,
                                                  input int dir, input bit st);
      element_word_type w;
      w.sample_re     = SAMPLE_W'(sr);
      w.sample_im     = SAMPLE_W'(si);
      w.weight_re     = SAMPLE_W'(wr);
      w.weight_im     = SAMPLE_W'(wi);
      w.last_element  = le;
      w.last_snapshot = ls;
      w.direction_id  = DIR_W'(dir);
      w.start_scan    = st;
      return w;
   endfunction

   function automatic beam_result_type expected_beam(input longint br, bi, input bit pv,
                                                     input longint pw, input bit np,
                                                     input int best, input longint peak);
      beam_result_type r;
      r.beam_re        = BEAM_W'(br);
      r.beam_im        = BEAM_W'(bi);
      r.power_valid    = pv;
      r.power          = POWER_W'(pw);
      r.new_peak       = np;
      r.best_direction = DIR_W'(best);
      r.peak_power     = POWER_W'(peak);
      return r;
   endfunction

   function automatic longint clamp_beam(input logic signed [SUM_W-1:0] total);
      longint v;
      v = longint'(total >>> BEAM_SHIFT);   // arithmetic shift floors
      if (v > BEAM_TOP) return BEAM_TOP;
      if (v < BEAM_BOTTOM) return BEAM_BOTTOM;
      return v;
   endfunction

   // Advance the predictor by one accepted element word; return 1 when the
   // word closes a snapshot and so owes a beam word.
   function automatic bit predict_beam(input element_word_type w, output beam_result_type r);
      longint           term_re, term_im, br, bi, mag;
      logic [POWER_W:0] power_sum;
      r = '0;
      if (w.start_scan) begin
         peak_power_q = '0;
         peak_dir_q   = '0;
      end
      term_re = longint'(w.weight_re) * longint'(w.sample_re)
              + longint'(w.weight_im) * longint'(w.sample_im);
      term_im = longint'(w.weight_re) * longint'(w.sample_im)
              - longint'(w.weight_im) * longint'(w.sample_re);
      // Sums wrap at their native width.
      sum_re_q = sum_re_q + term_re[SUM_W-1:0];
      sum_im_q = sum_im_q + term_im[SUM_W-1:0];
      if (!w.last_element) return 1'b0;

      br = clamp_beam(sum_re_q);
      bi = clamp_beam(sum_im_q);
      sum_re_q = '0;
      sum_im_q = '0;
      mag = br * br + bi * bi;
      power_sum = {1'b0, scan_power_q} + (POWER_W + 1)'(mag);
      scan_power_q = (power_sum > {1'b0, POWER_CAP}) ? POWER_CAP : power_sum[POWER_W-1:0];

      r.beam_re = br[BEAM_W-1:0];
      r.beam_im = bi[BEAM_W-1:0];
      if (w.last_snapshot) begin
         r.power_valid = 1'b1;
         r.power       = scan_power_q;
         // Only a strictly greater power takes the peak.
         if (scan_power_q > peak_power_q) begin
            peak_power_q = scan_power_q;
            peak_dir_q   = w.direction_id;
            r.new_peak   = 1'b1;
         end
         scan_power_q = '0;
      end
      r.best_direction = peak_dir_q;
      r.peak_power     = peak_power_q;
      return 1'b1;
   endfunction

   // Favor the rails, zero and minus one; mix in small and full-range values.
   function automatic int pick_q15();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return $urandom_range(0, 512) - 256;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic element_word_type random_word(input bit le, ls,
                                                    input logic [DIR_W-1:0] dir,
                                                    input bit st);
      return elem_word(pick_q15(), pick_q15(), pick_q15(), pick_q15(), le, ls, dir, st);
   endfunction

   // Present one element word, hold it until accepted, then predict. When
   // bursts are on, drop valid for a random gap at the end of each burst.
   task automatic send_word(input element_word_type w, input bit has_golden,
                            input beam_result_type golden);
      beam_result_type predicted;
      int              gap;
      req_bus.valid         <= 1'b1;
      req_bus.sample_re     <= w.sample_re;
      req_bus.sample_im     <= w.sample_im;
      req_bus.weight_re     <= w.weight_re;
      req_bus.weight_im     <= w.weight_im;
      req_bus.last_element  <= w.last_element;
      req_bus.last_snapshot <= w.last_snapshot;
      req_bus.direction_id  <= w.direction_id;
      req_bus.start_scan    <= w.start_scan;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (predict_beam(w, predicted)) begin
         beam_queue.push_back(has_golden ? golden : predicted);
      end
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (beam_queue.size() != 0) @(posedge clock);
   endtask

   // One scanned direction: a few short snapshots with random content. Now
   // and then leave the direction open, put a stray snapshot mark on an inner
   // element, switch the direction index midway, or start a scan mid-stream.
   task automatic send_random_direction();
      int               snaps, elems;
      logic [DIR_W-1:0] dir;
      bit               close_dir, le, ls, st;
      snaps     = $urandom_range(1, 4);
      dir       = DIR_W'($urandom);
      close_dir = ($urandom_range(0, 11) != 0);
      for (int s = 0; s < snaps; s++) begin
         elems = $urandom_range(1, 6);
         for (int e = 0; e < elems; e++) begin
            le = (e == elems - 1);
            ls = le ? (close_dir && s == snaps - 1) : ($urandom_range(0, 15) == 0);
            st = (s == 0 && e == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 39) == 0);
            if ($urandom_range(0, 19) == 0) dir = DIR_W'($urandom);
            send_word(random_word(le, ls, dir, st), 1'b0, NO_GOLDEN);
            random_words++;
         end
      end
   endtask

   // Two long snapshots of same-phase rail values: the real beam clips at the
   // positive rail, then at the negative rail.
   task automatic send_long_snapshots();
      int               len, x;
      element_word_type w;
      bit               le;
      for (int k = 0; k < 2; k++) begin
         len = $urandom_range(140, 150);
         x   = k[0] ? 32767 : -32768;
         for (int e = 0; e < len; e++) begin
            le = (e == len - 1);
            if ($urandom_range(0, 15) == 0) begin
               w = random_word(le, le && k[0], DIR_W'($urandom), 1'b0);
            end else begin
               w = elem_word(x, x, -32768, -32768, le, le && k[0],
                             $urandom_range(0, 16383), 1'b0);
            end
            send_word(w, 1'b0, NO_GOLDEN);
         end
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted beam word against the oldest expectation.
   always @(posedge clock) begin
      beam_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (beam_queue.size() == 0) begin
            $error("beam word with nothing expected");
            mismatches++;
         end else begin
            want = beam_queue.pop_front();
            check_field("beam_re", want.beam_re, rsp_bus.beam_re);
            check_field("beam_im", want.beam_im, rsp_bus.beam_im);
            check_field("power_valid", want.power_valid, rsp_bus.power_valid);
            check_field("power", want.power, rsp_bus.power);
            check_field("new_peak", want.new_peak, rsp_bus.new_peak);
            check_field("best_direction", want.best_direction, rsp_bus.best_direction);
            check_field("peak_power", want.peak_power, rsp_bus.peak_power);
         end
      end
   end

   // Receiver: alternate free-running stretches with choppy ones where ready
   // drops for random stretches at a time.
   initial begin : rsp_stall_pattern
      int mode_left, run_left;
      bit choppy, level;
      mode_left = 0;
      run_left  = 0;
      choppy    = 1'b0;
      level     = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            choppy    = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (choppy) begin
            if (run_left == 0) begin
               level    = !level;
               run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 12);
            end
            run_left--;
         end else begin
            level = 1'b1;
         end
         rsp_bus.ready <= level;
      end
   end

   // Count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : hang_watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("beamformer_power_scan_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      // Directed table. Rows with a golden word were worked out by hand;
      // the rest go through the predictor.
      // Zero snapshot straight out of reset: zero power, peak untouched.
      directed_rows.push_back({elem_word(0, 0, 0, 0, 1, 1, 5, 0), 1'b1,
                               expected_beam(0, 0, 1, 0, 0, 0, 0)});
      // All four inputs at the negative rail: term is 2^31 + j0.
      directed_rows.push_back({elem_word(-32768, -32768, -32768, -32768, 1, 1, 16383, 0), 1'b1,
                               expected_beam(65536, 0, 1, 64'h1_0000_0000, 1, 16383,
                                             64'h1_0000_0000)});
      // Same power again: a tie keeps the old peak.
      directed_rows.push_back({elem_word(-32768, -32768, -32768, -32768, 1, 1, 7, 0), 1'b1,
                               expected_beam(65536, 0, 1, 64'h1_0000_0000, 0, 16383,
                                             64'h1_0000_0000)});
      // Snapshot mark without element mark: no word, sum becomes -1.
      directed_rows.push_back({elem_word(1, 0, -1, 0, 0, 1, 3, 0), 1'b0, NO_GOLDEN});
      // Close the snapshot, direction stays open; -1 floors to -1.
      directed_rows.push_back({elem_word(0, 0, 0, 0, 1, 0, 3, 0), 1'b1,
                               expected_beam(-1, 0, 0, 0, 0, 16383, 64'h1_0000_0000)});
      // Scan start in mid-snapshot clears the peak but not the sums.
      directed_rows.push_back({elem_word(32767, 32767, 32767, -32768, 0, 0, 0, 0), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(-32768, 32767, 32767, 32767, 0, 0, 0, 1), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(12345, -23456, -1, 1, 1, 1, 100, 0), 1'b0, NO_GOLDEN});
      // Scan start on a closing zero word: zero power cannot become a peak.
      directed_rows.push_back({elem_word(0, 0, 0, 0, 1, 1, 9, 1), 1'b1,
                               expected_beam(0, 0, 1, 0, 0, 0, 0)});
      directed_rows.push_back({elem_word(32767, -32768, -32768, 32767, 1, 0, 0, 0), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(-32768, 32767, 32767, -32768, 1, 1, 10922, 0), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(21845, -21846, -21846, 21845, 0, 0, 5461, 1), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(-21846, 21845, 21845, -21846, 1, 1, 5461, 0), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(-32768, -32768, 32767, 32767, 1, 1, 16383, 0), 1'b0,
                               NO_GOLDEN});
      directed_rows.push_back({elem_word(32767, 32767, -32768, -32768, 1, 1, 0, 0), 1'b0,
                               NO_GOLDEN});

      // Hold every input at a known value through reset.
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.sample_re     <= '0;
      req_bus.sample_im     <= '0;
      req_bus.weight_re     <= '0;
      req_bus.weight_im     <= '0;
      req_bus.last_element  <= 1'b0;
      req_bus.last_snapshot <= 1'b0;
      req_bus.direction_id  <= '0;
      req_bus.start_scan    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].has_golden, directed_rows[i].golden);
      end

      // Hold the sender until every beam word is back.
      wait_for_drain();

      while (random_words < RANDOM_WORDS) send_random_direction();
      send_long_snapshots();
      // A few more directions to see the sums restart after clipping.
      for (int i = 0; i < 5; i++) send_random_direction();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("beamformer_power_scan_test: done, clean");
      end else begin
         $display("beamformer_power_scan_test: done, errors");
      end
      $finish;
   end

endmodule
